>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked on clk, masked while rst_n is low
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// clocked on clk, also checked during reset
`define ASSERT_CLK_NR(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

>>> rtl/core/tbc_pkg.sv
// ---------------------------------------------------------------------------
// tbc_pkg
// Widths, types and limb helpers of the barycentric weight pipeline.
// ---------------------------------------------------------------------------
package tbc_pkg;

  localparam int CW     = 32;          // Q16.16 coordinate
  localparam int EW     = CW + 1;      // edge vector component
  localparam int SQW    = 2 * EW;      // one component product
  localparam int DOTW   = SQW + 1;     // dot product
  localparam int LIMBW  = 22;          // low limb width of a dot product
  localparam int LOPW   = DOTW - 2 * LIMBW + 1; // signed limb operand (24)
  localparam int PPW    = 2 * LOPW;    // partial product
  localparam int NW     = 2 * DOTW + 4; // den / numerators, signed
  localparam int FRACW  = 16;
  localparam int QW     = 32;          // quotient bits kept
  localparam int DW     = NW + QW;     // divider remainder width
  localparam int NDOT   = 5;
  localparam int NPROD  = 6;

  typedef logic signed [CW-1:0]   coord_t;
  typedef logic signed [EW-1:0]   edge_t;
  typedef logic signed [SQW-1:0]  sq_t;
  typedef logic signed [DOTW-1:0] dot_t;
  typedef logic signed [LOPW-1:0] limb_t;
  typedef logic signed [PPW-1:0]  pp_t;
  typedef logic signed [NW-1:0]   wide_t;
  typedef logic [NW-1:0]          mag_t;
  typedef logic [DW-1:0]          rem_t;
  typedef logic [QW-1:0]          quo_t;

  // signed operand of limb idx: two unsigned low limbs, signed top limb
  function automatic limb_t limb(input dot_t x, input logic [1:0] idx);
    limb_t r;
    if (idx == 2'd2) begin
      r = limb_t'($signed(x[DOTW-1:2*LIMBW]));
    end else begin
      r = limb_t'({2'b00, x[idx*LIMBW +: LIMBW]});
    end
    return r;
  endfunction

endpackage

>>> rtl/core/tbc_in_if.sv
// ---------------------------------------------------------------------------
// tbc_in_if
// Input channel: triangle corners and query point, valid/ready.
// ---------------------------------------------------------------------------
interface tbc_in_if;
  logic            valid;
  logic            ready;
  tbc_pkg::coord_t a_x, a_y, a_z;
  tbc_pkg::coord_t b_x, b_y, b_z;
  tbc_pkg::coord_t c_x, c_y, c_z;
  tbc_pkg::coord_t p_x, p_y, p_z;

  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z,
                  c_x, c_y, c_z, p_x, p_y, p_z, input ready);
  modport sink   (input valid, a_x, a_y, a_z, b_x, b_y, b_z,
                  c_x, c_y, c_z, p_x, p_y, p_z, output ready);
endinterface

>>> rtl/core/tbc_out_if.sv
// ---------------------------------------------------------------------------
// tbc_out_if
// Result channel: three Q16.16 weights and the degenerate flag.
// ---------------------------------------------------------------------------
interface tbc_out_if;
  logic            valid;
  logic            ready;
  tbc_pkg::coord_t weight_u;
  tbc_pkg::coord_t weight_v;
  tbc_pkg::coord_t weight_w;
  logic            degenerate;

  modport source (output valid, weight_u, weight_v, weight_w, degenerate,
                  input ready);
  modport sink   (input valid, weight_u, weight_v, weight_w, degenerate,
                  output ready);
endinterface

>>> rtl/core/triangle_barycentric_coords.sv
// ---------------------------------------------------------------------------
// triangle_barycentric_coords
// Barycentric weights of a point against a 3-D triangle, Q16.16, pipelined.
// ---------------------------------------------------------------------------
//  channel  dir  handshake      word
//  in_ch    in   valid / ready  corners a, b, c and point p
//  out_ch   out  valid / ready  weight_u, weight_v, weight_w, degenerate
//
//  One word per cycle while the output is not stalled; 10 arithmetic stages,
//  32 restoring-division stages of one quotient bit each, one output stage.
//  The division stages set the depth. rst_n (sync) clears only valid bits.
//  A stalled output freezes the whole pipeline; in_ch.ready drops with it.
// ---------------------------------------------------------------------------
module triangle_barycentric_coords (
  input  logic       clk,
  input  logic       rst_n,
  tbc_in_if.sink     in_ch,
  tbc_out_if.source  out_ch
);

  localparam int NPRE = 10;
  localparam int NSTG = NPRE + tbc_pkg::QW + 1;

  // dot product operand pairs: d00 d01 d11 d20 d21
  localparam int DA [tbc_pkg::NDOT] = '{0, 0, 1, 2, 2};
  localparam int DB [tbc_pkg::NDOT] = '{0, 1, 1, 0, 1};
  // products: d00*d11 d01*d01 d11*d20 d01*d21 d00*d21 d01*d20
  localparam int PA [tbc_pkg::NPROD] = '{0, 1, 2, 1, 0, 1};
  localparam int PB [tbc_pkg::NPROD] = '{2, 1, 3, 4, 4, 3};

  logic            en;
  logic [NSTG-1:0] vld_r;

  tbc_pkg::coord_t  pt     [4][3];
  tbc_pkg::edge_t   edge_r [3][3];
  tbc_pkg::sq_t     sq_r   [tbc_pkg::NDOT][3];
  tbc_pkg::dot_t    dot_r  [tbc_pkg::NDOT];
  tbc_pkg::pp_t     pp_r   [tbc_pkg::NPROD][3][3];
  tbc_pkg::wide_t   row_r  [tbc_pkg::NPROD][3];
  tbc_pkg::wide_t   prod_r [tbc_pkg::NPROD];
  tbc_pkg::wide_t   den7_r, nv7_r, nw7_r;
  tbc_pkg::wide_t   num8_r [3];
  tbc_pkg::wide_t   den8_r;
  logic             dg8_r;
  tbc_pkg::mag_t    mag9_r [3];
  tbc_pkg::mag_t    dmag9_r;
  logic [2:0]       neg9_r;
  logic             dg9_r;

  // division pipe; index 0 is loaded by the tenth stage
  tbc_pkg::rem_t    rem_r  [tbc_pkg::QW+1][3];
  tbc_pkg::quo_t    quo_r  [tbc_pkg::QW+1][3];
  tbc_pkg::mag_t    dv_r   [tbc_pkg::QW+1];
  logic [2:0]       neg_r  [tbc_pkg::QW+1];
  logic [2:0]       ovf_r  [tbc_pkg::QW+1];
  logic             dg_r   [tbc_pkg::QW+1];

  tbc_pkg::coord_t  wt_nxt [3];
  tbc_pkg::coord_t  wt_r   [3];
  logic             dg_out_r;

  assign en          = !vld_r[NSTG-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_ch.valid};
    end
  end

  always_comb begin
    pt[0] = '{in_ch.a_x, in_ch.a_y, in_ch.a_z};
    pt[1] = '{in_ch.b_x, in_ch.b_y, in_ch.b_z};
    pt[2] = '{in_ch.c_x, in_ch.c_y, in_ch.c_z};
    pt[3] = '{in_ch.p_x, in_ch.p_y, in_ch.p_z};
  end

  // stages 1..10
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          edge_r[k][i] <= tbc_pkg::edge_t'(pt[k+1][i]) - tbc_pkg::edge_t'(pt[0][i]);
        end
      end
      for (int d = 0; d < tbc_pkg::NDOT; d++) begin
        for (int i = 0; i < 3; i++) begin
          sq_r[d][i] <= tbc_pkg::sq_t'(edge_r[DA[d]][i]) * tbc_pkg::sq_t'(edge_r[DB[d]][i]);
        end
        dot_r[d] <= tbc_pkg::dot_t'(sq_r[d][0]) + tbc_pkg::dot_t'(sq_r[d][1])
                  + tbc_pkg::dot_t'(sq_r[d][2]);
      end
      for (int p = 0; p < tbc_pkg::NPROD; p++) begin
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            pp_r[p][i][j] <= tbc_pkg::pp_t'(tbc_pkg::limb(dot_r[PA[p]], 2'(i)))
                           * tbc_pkg::pp_t'(tbc_pkg::limb(dot_r[PB[p]], 2'(j)));
          end
          row_r[p][i] <= tbc_pkg::wide_t'(pp_r[p][i][0])
                       + (tbc_pkg::wide_t'(pp_r[p][i][1]) <<< tbc_pkg::LIMBW)
                       + (tbc_pkg::wide_t'(pp_r[p][i][2]) <<< (2 * tbc_pkg::LIMBW));
        end
        prod_r[p] <= row_r[p][0] + (row_r[p][1] <<< tbc_pkg::LIMBW)
                   + (row_r[p][2] <<< (2 * tbc_pkg::LIMBW));
      end
      den7_r <= prod_r[0] - prod_r[1];
      nv7_r  <= prod_r[2] - prod_r[3];
      nw7_r  <= prod_r[4] - prod_r[5];
      num8_r[0] <= den7_r - nv7_r - nw7_r;
      num8_r[1] <= nv7_r;
      num8_r[2] <= nw7_r;
      den8_r    <= den7_r;
      dg8_r     <= (den7_r == '0);
      for (int i = 0; i < 3; i++) begin
        mag9_r[i] <= num8_r[i][tbc_pkg::NW-1] ? tbc_pkg::mag_t'(-num8_r[i])
                                              : tbc_pkg::mag_t'(num8_r[i]);
        neg9_r[i] <= num8_r[i][tbc_pkg::NW-1] ^ den8_r[tbc_pkg::NW-1];
      end
      dmag9_r <= den8_r[tbc_pkg::NW-1] ? tbc_pkg::mag_t'(-den8_r)
                                       : tbc_pkg::mag_t'(den8_r);
      dg9_r   <= dg8_r;
      for (int i = 0; i < 3; i++) begin
        rem_r[0][i] <= tbc_pkg::rem_t'(mag9_r[i]) << tbc_pkg::FRACW;
        quo_r[0][i] <= '0;
        // quotient needs more than QW bits
        ovf_r[0][i] <= (tbc_pkg::rem_t'(mag9_r[i]) << tbc_pkg::FRACW)
                    >= (tbc_pkg::rem_t'(dmag9_r) << tbc_pkg::QW);
      end
      dv_r[0]  <= dmag9_r;
      neg_r[0] <= neg9_r;
      dg_r[0]  <= dg9_r;
    end
  end

  // one quotient bit per stage, MSB first
  for (genvar s = 0; s < tbc_pkg::QW; s++) begin : g_div
    localparam int BIT = tbc_pkg::QW - 1 - s;
    logic [tbc_pkg::DW:0] diff;
    tbc_pkg::rem_t        rem_nxt [3];
    tbc_pkg::quo_t        quo_nxt [3];

    always_comb begin
      diff = '0;
      for (int i = 0; i < 3; i++) begin
        diff = {1'b0, rem_r[s][i]} - {1'b0, tbc_pkg::rem_t'(dv_r[s]) << BIT};
        rem_nxt[i] = rem_r[s][i];
        quo_nxt[i] = quo_r[s][i];
        if (!diff[tbc_pkg::DW]) begin
          rem_nxt[i]      = diff[tbc_pkg::DW-1:0];
          quo_nxt[i][BIT] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1] <= rem_nxt;
        quo_r[s+1] <= quo_nxt;
        dv_r[s+1]  <= dv_r[s];
        neg_r[s+1] <= neg_r[s];
        ovf_r[s+1] <= ovf_r[s];
        dg_r[s+1]  <= dg_r[s];
      end
    end
  end

  // sign, saturation and zero weights for a degenerate triangle
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dg_r[tbc_pkg::QW]) begin
        wt_nxt[i] = '0;
      end else if (neg_r[tbc_pkg::QW][i]) begin
        if (ovf_r[tbc_pkg::QW][i] || quo_r[tbc_pkg::QW][i][tbc_pkg::QW-1]) begin
          wt_nxt[i] = {1'b1, {(tbc_pkg::CW-1){1'b0}}};
        end else begin
          wt_nxt[i] = tbc_pkg::coord_t'(-quo_r[tbc_pkg::QW][i]);
        end
      end else begin
        if (ovf_r[tbc_pkg::QW][i] || quo_r[tbc_pkg::QW][i][tbc_pkg::QW-1]) begin
          wt_nxt[i] = {1'b0, {(tbc_pkg::CW-1){1'b1}}};
        end else begin
          wt_nxt[i] = tbc_pkg::coord_t'(quo_r[tbc_pkg::QW][i]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wt_r     <= wt_nxt;
      dg_out_r <= dg_r[tbc_pkg::QW];
    end
  end

  assign out_ch.valid      = vld_r[NSTG-1];
  assign out_ch.weight_u   = wt_r[0];
  assign out_ch.weight_v   = wt_r[1];
  assign out_ch.weight_w   = wt_r[2];
  assign out_ch.degenerate = dg_out_r;

endmodule

>>> rtl/core/tbc_checker.sv
// ---------------------------------------------------------------------------
// tbc_checker
// Port-level checks of the barycentric weight pipeline, bound to the top.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tbc_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input tbc_pkg::coord_t weight_u,
  input tbc_pkg::coord_t weight_v,
  input tbc_pkg::coord_t weight_w,
  input logic            degenerate
);

  `ASSERT_CLK_NR(a_reset_clears, !rst_n |=> !out_valid)
  `ASSERT_CLK(a_ready_follows_out, in_ready == (!out_valid || out_ready))
  `ASSERT_CLK(a_degen_zero, (out_valid && degenerate) |-> ({weight_u, weight_v, weight_w} == '0))
  `ASSERT_CLK(a_valid_holds, (out_valid && !out_ready) |=> out_valid)

endmodule

bind triangle_barycentric_coords tbc_checker u_tbc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .weight_u   (out_ch.weight_u),
  .weight_v   (out_ch.weight_v),
  .weight_w   (out_ch.weight_w),
  .degenerate (out_ch.degenerate)
);
